// ----- design/line_history_ring_assert.svh -----
// Assertion macros used by the checker of the history ring.
`ifndef LINE_HISTORY_RING_ASSERT_SVH
`define LINE_HISTORY_RING_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define LHR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define LHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lhr_pkg.sv -----
package lhr_pkg;

    // Fixed field widths of the command and result words
    localparam int CMD_W  = 2;
    localparam int LINE_W = 32;
    localparam int STEP_W = 8;

    typedef logic [CMD_W-1:0] t_cmd;

    // Command codes
    localparam t_cmd CMD_COMMIT = 2'd0;
    localparam t_cmd CMD_CLEAR  = 2'd1;
    localparam t_cmd CMD_SELECT = 2'd2;

endpackage

// ----- design/lhr_ram.sv -----
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read and a write to the same address in one cycle return the old data.
module lhr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/line_history_ring.sv -----
// Command-line history ring. One command word is taken in every clock cycle
// (busy stays low); its result word appears with o_valid high for exactly one
// cycle, the cycle after the command was taken, because the handle comes out
// of a RAM with registered read data. The receiver cannot stall, so it
// must capture o_ok and o_entry_handle whenever o_valid is high. Slot
// occupancy is tracked by the write index and a wrap flag rather than a valid
// bit per slot, so the ring is usable right after reset with no clearing pass.
// Commit and clear always return ok with a zero handle; select returns ok and
// the stored handle, or not ok and zero; an unused command code returns not ok.
module line_history_ring #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lhr_pkg::CMD_W-1:0]   i_command,
    input  logic [lhr_pkg::LINE_W-1:0]  i_line_handle,
    input  logic [lhr_pkg::STEP_W-1:0]  i_step,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic [lhr_pkg::LINE_W-1:0]  o_entry_handle
);

    localparam int IW = $clog2(DEPTH);
    localparam int TW = ((IW > lhr_pkg::STEP_W) ? IW : lhr_pkg::STEP_W) + 2;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(DEPTH);
    localparam logic [TW-1:0] DEPTH_T  = TW'(DEPTH);

    // control state
    logic [IW-1:0] r_wi,      n_wi;
    logic [IW-1:0] r_cursor,  n_cursor;
    logic          r_wrapped, n_wrapped;
    logic          r_saved,   n_saved;
    // result stage
    logic                   r_valid, r_ok, r_hit, r_fwd;
    logic [HANDLE_BITS-1:0] r_fwd_data;

    logic                   accept;
    logic                   is_commit, is_clear, is_select, save;
    logic [TW-1:0]          target;
    logic                   in_range;
    logic [IW-1:0]          tgt;
    logic [IW:0]            diff, slot_x;
    logic [IW-1:0]          slot;
    logic                   slot_valid, hit, we;
    logic [HANDLE_BITS+lhr_pkg::LINE_W-1:0] w_wide;
    logic [HANDLE_BITS-1:0] wdata, rdata, sel_data;
    logic [HANDLE_BITS+lhr_pkg::LINE_W-1:0] o_wide;

    // never stalls: every command finishes its state update at acceptance
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign is_commit = accept && (i_command == lhr_pkg::CMD_COMMIT);
    assign is_clear  = accept && (i_command == lhr_pkg::CMD_CLEAR);
    assign is_select = accept && (i_command == lhr_pkg::CMD_SELECT);
    // select with cursor at home saves the current line first
    assign save      = is_select && (r_cursor == '0);

    // target = cursor + step, range check
    assign target   = {{(TW - IW){1'b0}}, r_cursor}
                    + {{(TW - lhr_pkg::STEP_W){i_step[lhr_pkg::STEP_W-1]}}, i_step};
    assign in_range = !target[TW-1] && (target < DEPTH_T);
    assign tgt      = target[IW-1:0];

    // slot = (write index - target) mod DEPTH
    assign diff   = {1'b0, r_wi} - {1'b0, tgt};
    assign slot_x = diff[IW] ? (diff + DEPTH_X) : diff;
    assign slot   = slot_x[IW-1:0];

    // occupancy: everything once wrapped, else below write index, plus
    // the write slot itself when a save has landed there
    assign slot_valid = r_wrapped || (slot < r_wi)
                     || ((slot == r_wi) && (r_saved || save));
    assign hit        = is_select && in_range && slot_valid;

    // handle kept to HANDLE_BITS
    assign w_wide = {{HANDLE_BITS{1'b0}}, i_line_handle};
    assign wdata  = w_wide[HANDLE_BITS-1:0];
    assign we     = is_commit || save;

    // next state
    always_comb begin
        n_wi      = r_wi;
        n_cursor  = r_cursor;
        n_wrapped = r_wrapped;
        n_saved   = r_saved;
        if (is_commit) begin
            n_cursor = '0;
            n_saved  = 1'b0;
            if (r_wi == LAST_IDX) begin
                n_wi      = '0;
                n_wrapped = 1'b1;
            end else begin
                n_wi = r_wi + 1'b1;
            end
        end else if (is_clear) begin
            n_cursor = '0;
        end else if (is_select) begin
            if (save) begin
                n_saved = 1'b1;
            end
            if (hit) begin
                n_cursor = tgt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi      <= '0;
            r_cursor  <= '0;
            r_wrapped <= 1'b0;
            r_saved   <= 1'b0;
            r_valid   <= 1'b0;
            r_ok      <= 1'b0;
            r_hit     <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_wi      <= n_wi;
            r_cursor  <= n_cursor;
            r_wrapped <= n_wrapped;
            r_saved   <= n_saved;
            r_valid   <= accept;
            r_ok      <= is_commit || is_clear || hit;
            r_hit     <= hit;
            // read of the slot written in the same cycle: take the new word
            r_fwd     <= hit && save && (slot == r_wi);
        end
    end

    // forwarded write data, payload only
    always_ff @(posedge i_clk) begin
        r_fwd_data <= wdata;
    end

    lhr_ram #(
        .DEPTH (DEPTH),
        .WIDTH (HANDLE_BITS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wi),
        .i_wdata (wdata),
        .i_re    (hit),
        .i_raddr (slot),
        .o_rdata (rdata)
    );

    // result word
    assign sel_data       = r_fwd ? r_fwd_data : rdata;
    assign o_wide         = r_hit ? {{lhr_pkg::LINE_W{1'b0}}, sel_data} : '0;
    assign o_valid        = r_valid;
    assign o_ok           = r_ok;
    assign o_entry_handle = o_wide[lhr_pkg::LINE_W-1:0];

endmodule

// ----- design/lhr_checker.sv -----
`include "line_history_ring_assert.svh"

// Port-level checks of the history ring.
module lhr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [lhr_pkg::CMD_W-1:0]  i_command,
    input logic                       o_valid,
    input logic                       o_ok,
    input logic [lhr_pkg::LINE_W-1:0] o_entry_handle
);

    logic accept;
    assign accept = start && !busy;

    // every taken word yields one result word in the next cycle
    `LHR_ASSERT_NEXT(a_result_follows, accept, o_valid, "result word missing")
    // no result word without a taken word
    `LHR_ASSERT_NOW(a_no_spurious, o_valid, $past(accept), "unexpected result word")
    // a failed or unused command carries a zero handle
    `LHR_ASSERT_NOW(a_zero_on_fail, !o_ok, o_entry_handle == '0, "handle not zero on fail")
    // commit and clear always succeed with a zero handle
    `LHR_ASSERT_NEXT(a_commit_clear_ok,
        accept && ((i_command == lhr_pkg::CMD_COMMIT) || (i_command == lhr_pkg::CMD_CLEAR)),
        o_ok && (o_entry_handle == '0), "commit or clear result wrong")

endmodule

bind line_history_ring lhr_checker u_lhr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_command      (i_command),
    .o_valid        (o_valid),
    .o_ok           (o_ok),
    .o_entry_handle (o_entry_handle)
);
